>>> rtl/core/passsp_pkg.sv
// Shared types, widths and constants of the partitioned shortest-path engine.
package passsp_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 8192;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 13;
  localparam int OFFS_W  = 14;
  localparam int TGT_W   = 10;
  localparam int WGT_W   = 16;
  localparam int DIST_W  = 31;
  localparam int WORK_W  = 63;
  localparam int VCNT_W  = 11;
  localparam int PS_W    = 7;
  localparam int SRC_W   = 10;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [DIST_W-1:0] INF_DIST = 31'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] SAT_DIST = 31'h7FFF_FFFE;

  localparam logic [1:0] REG_VCOUNT = 2'd0;
  localparam logic [1:0] REG_PSIZE  = 2'd1;
  localparam logic [1:0] REG_SOURCE = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ROW  = 2'd0,
    CMD_LOAD_EDGE = 2'd1,
    CMD_RUN       = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic {
    ALU_RELAX = 1'b0,
    ALU_CMP   = 1'b1
  } alu_op_e;

  // Effective configuration after degenerate values are folded
  typedef struct packed {
    logic [VCNT_W-1:0] n;
    logic [PS_W-1:0]   ps;
    logic [SRC_W-1:0]  src;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] val;
    logic              lt;
  } alu_res_t;

endpackage

>>> rtl/core/partitioned_async_sssp_stack_order_top.sv
// Partitioned asynchronous Bellman-Ford shortest-path engine, top level.
// Row-offset loads, edge loads and reads each take one transaction; loads
// return their result the next cycle, reads after one registered RAM read.
// A run first sweeps all MAX_VERTICES entries of the vertex state, one per
// cycle, then serves partitions from the FIFO: each serve clears the
// per-serve marks of vertex_count entries, visits each vertex of the
// partition, relaxes each out-edge of an active vertex, runs the update
// pass over every vertex and moves each queued partition to the FIFO. All
// of this runs through one saturating add/compare unit and single-port RAM
// reads, so the block accepts nothing else until the run result is out.
module partitioned_async_sssp_stack_order_top
  import passsp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [OFFS_W-1:0]  offset_value_i,
  input  logic [TGT_W-1:0]   edge_target_i,
  input  logic [WGT_W-1:0]   edge_weight_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DIST_W-1:0]  distance_o,
  output logic               reached_o,
  output logic [WORK_W-1:0]  work_count_o,
  output logic               done_res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int OW  = $clog2(MAX_EDGES + 1);
  localparam int EDW = TGT_W + WEIGHT_BITS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_INIT, ST_SEED, ST_FETCH, ST_POP, ST_CLR,
    ST_VA, ST_VB, ST_VC, ST_EA, ST_EB, ST_EC, ST_ED,
    ST_PA, ST_PB, ST_SA, ST_SB, ST_DONE
  } state_e;

  cfg_t     cfg;
  alu_res_t alu;
  alu_op_e  alu_op;
  logic [DIST_W-1:0] alu_a, alu_b, alu_c;

  state_e             state_q;
  logic               out_valid_q;
  logic [DIST_W-1:0]  dist_q;
  logic               reached_q;
  logic [WORK_W-1:0]  work_out_q;
  logic               done_q;
  logic [WORK_W-1:0]  work_q;
  logic               run_seen_q;
  logic               rd_ok_q;
  logic [NW-1:0]      idx_q;
  logic [VW-1:0]      pv_q;
  logic [PS_W-1:0]    poff_q;
  logic [VW-1:0]      src_part_q;
  logic [VW-1:0]      head_q;
  logic [NW-1:0]      fcnt_q;
  logic [NW-1:0]      scnt_q;
  logic [NW-1:0]      lo_q;
  logic [NW-1:0]      hi_q;
  logic [NW-1:0]      u_q;
  logic [OW-1:0]      e_q;
  logic [OW-1:0]      e1_q;
  logic               act_q;
  logic [DIST_W-1:0]  su_q;
  logic [VW-1:0]      t_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [VW-1:0]      pt_q;
  logic [DIST_W-1:0]  newc_q;
  logic [DIST_W-1:0]  stt_q;
  logic [2*PS_W-1:0]  psq_q;

  // RAM ports
  logic              row_we;
  logic [NW-1:0]     row_waddr, row_raddr;
  logic [OFFS_W-1:0] row_wdata, row_rdata;
  logic              edge_we;
  logic [EW-1:0]     edge_waddr, edge_raddr;
  logic [EDW-1:0]    edge_wdata, edge_rdata;
  logic              sd_we, cd_we;
  logic [VW-1:0]     sd_waddr, sd_raddr, cd_waddr, cd_raddr;
  logic [DIST_W-1:0] sd_wdata, sd_rdata, cd_wdata, cd_rdata;
  logic              act_we, imp_we, pnd_we, tch_we;
  logic [VW-1:0]     act_waddr, act_raddr, imp_waddr, imp_raddr;
  logic [VW-1:0]     pnd_waddr, pnd_raddr, tch_waddr, tch_raddr;
  logic              act_wdata, act_rdata, imp_wdata, imp_rdata;
  logic              pnd_wdata, pnd_rdata, tch_wdata, tch_rdata;
  logic              vp_we, ff_we, sk_we;
  logic [VW-1:0]     vp_waddr, vp_raddr, ff_waddr, ff_raddr, sk_waddr, sk_raddr;
  logic [VW-1:0]     vp_wdata, vp_rdata, ff_wdata, ff_rdata, sk_wdata, sk_rdata;

  logic              in_acc;
  logic [NW-1:0]     n_v;
  logic [31:0]       slot32, src32, tv32, wgt32, row32, clamp32, tail32, hi32;
  logic              src_ok, t_ok;
  logic [OW-1:0]     e_clamp;
  logic [VW+PS_W-1:0] lo_prod;
  logic [NW-1:0]     scnt_m1;
  logic              pb_move, pb_push, last_off;

  passsp_cfg #(.MAX_VERTICES(MAX_VERTICES)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  passsp_alu u_alu (
    .op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .c_i(alu_c), .res_o(alu)
  );

  passsp_ram #(.WIDTH(OFFS_W), .DEPTH(MAX_VERTICES + 1)) u_row (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .raddr_i(row_raddr), .rdata_o(row_rdata));
  passsp_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata));
  passsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_settled (
    .clk_i, .we_i(sd_we), .waddr_i(sd_waddr), .wdata_i(sd_wdata),
    .raddr_i(sd_raddr), .rdata_o(sd_rdata));
  passsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_cand (
    .clk_i, .we_i(cd_we), .waddr_i(cd_waddr), .wdata_i(cd_wdata),
    .raddr_i(cd_raddr), .rdata_o(cd_rdata));
  passsp_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_active (
    .clk_i, .we_i(act_we), .waddr_i(act_waddr), .wdata_i(act_wdata),
    .raddr_i(act_raddr), .rdata_o(act_rdata));
  passsp_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_improved (
    .clk_i, .we_i(imp_we), .waddr_i(imp_waddr), .wdata_i(imp_wdata),
    .raddr_i(imp_raddr), .rdata_o(imp_rdata));
  passsp_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_pending (
    .clk_i, .we_i(pnd_we), .waddr_i(pnd_waddr), .wdata_i(pnd_wdata),
    .raddr_i(pnd_raddr), .rdata_o(pnd_rdata));
  passsp_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_touched (
    .clk_i, .we_i(tch_we), .waddr_i(tch_waddr), .wdata_i(tch_wdata),
    .raddr_i(tch_raddr), .rdata_o(tch_rdata));
  passsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vpart (
    .clk_i, .we_i(vp_we), .waddr_i(vp_waddr), .wdata_i(vp_wdata),
    .raddr_i(vp_raddr), .rdata_o(vp_rdata));
  passsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fifo (
    .clk_i, .we_i(ff_we), .waddr_i(ff_waddr), .wdata_i(ff_wdata),
    .raddr_i(ff_raddr), .rdata_o(ff_rdata));
  passsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(sk_we), .waddr_i(sk_waddr), .wdata_i(sk_wdata),
    .raddr_i(sk_raddr), .rdata_o(sk_rdata));

  assign in_stall_o = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o  = out_valid_q;
  assign distance_o   = dist_q;
  assign reached_o    = reached_q;
  assign work_count_o = work_out_q;
  assign done_res_o   = done_q;

  always_comb begin
    n_v     = NW'(cfg.n);
    slot32  = 32'(slot_i);
    src32   = 32'(cfg.src);
    src_ok  = src32 < 32'(n_v);
    wgt32   = 32'(edge_weight_i);
    tv32    = 32'(edge_rdata[EDW-1:WEIGHT_BITS]);
    t_ok    = tv32 < 32'(n_v);
    row32   = 32'(row_rdata);
    clamp32 = (row32 > MAX_EDGES) ? MAX_EDGES : row32;
    e_clamp = clamp32[OW-1:0];
    tail32  = 32'(head_q) + 32'(fcnt_q);
    if (tail32 >= MAX_VERTICES) begin
      tail32 = tail32 - MAX_VERTICES;
    end
    hi32    = 32'(lo_q) + 32'(cfg.ps);
    if (hi32 > 32'(n_v)) begin
      hi32 = 32'(n_v);
    end
    lo_prod  = ff_rdata * cfg.ps;
    scnt_m1  = scnt_q - NW'(1);
    last_off = (poff_q + PS_W'(1)) == cfg.ps;
    pb_move  = imp_rdata && alu.lt;
    pb_push  = pb_move && !pnd_rdata && (32'(scnt_q) < MAX_VERTICES);
  end

  // Shared unit operands
  always_comb begin
    alu_op = ALU_CMP;
    alu_a  = '0;
    alu_b  = '0;
    alu_c  = '0;
    case (state_q)
      ST_EC: begin
        alu_op = ALU_RELAX;
        alu_a  = su_q;
        alu_b  = DIST_W'(w_q);
        alu_c  = cd_rdata;
      end
      ST_ED: begin
        alu_a = newc_q;
        alu_c = stt_q;
      end
      ST_PB: begin
        alu_a = cd_rdata;
        alu_c = sd_rdata;
      end
      default: ;
    endcase
  end

  // RAM port control
  always_comb begin
    row_we = 1'b0; row_waddr = slot32[NW-1:0]; row_wdata = offset_value_i;
    row_raddr = u_q;
    edge_we = 1'b0; edge_waddr = slot32[EW-1:0];
    edge_wdata = {edge_target_i, wgt32[WEIGHT_BITS-1:0]};
    edge_raddr = e_q[EW-1:0];
    sd_we = 1'b0; sd_waddr = idx_q[VW-1:0]; sd_wdata = INF_DIST;
    sd_raddr = idx_q[VW-1:0];
    cd_we = 1'b0; cd_waddr = idx_q[VW-1:0]; cd_wdata = INF_DIST;
    cd_raddr = idx_q[VW-1:0];
    act_we = 1'b0; act_waddr = idx_q[VW-1:0]; act_wdata = 1'b0;
    act_raddr = u_q[VW-1:0];
    imp_we = 1'b0; imp_waddr = idx_q[VW-1:0]; imp_wdata = 1'b0;
    imp_raddr = idx_q[VW-1:0];
    pnd_we = 1'b0; pnd_waddr = idx_q[VW-1:0]; pnd_wdata = 1'b0;
    pnd_raddr = pv_q;
    tch_we = 1'b0; tch_waddr = idx_q[VW-1:0]; tch_wdata = 1'b0;
    tch_raddr = vp_rdata;
    vp_we = 1'b0; vp_waddr = idx_q[VW-1:0]; vp_wdata = pv_q;
    vp_raddr = tv32[VW-1:0];
    ff_we = 1'b0; ff_waddr = tail32[VW-1:0]; ff_wdata = sk_rdata;
    ff_raddr = head_q;
    sk_we = 1'b0; sk_waddr = scnt_q[VW-1:0]; sk_wdata = pv_q;
    sk_raddr = scnt_m1[VW-1:0];
    case (state_q)
      ST_IDLE: begin
        sd_raddr = slot32[VW-1:0];
        if (in_acc && cmd_e'(command_i) == CMD_LOAD_ROW && slot32 <= MAX_VERTICES) begin
          row_we = 1'b1;
        end
        if (in_acc && cmd_e'(command_i) == CMD_LOAD_EDGE && slot32 < MAX_EDGES) begin
          edge_we = 1'b1;
        end
      end
      ST_INIT: begin
        sd_we  = 1'b1;
        cd_we  = 1'b1;
        act_we = 1'b1;
        imp_we = 1'b1;
        pnd_we = 1'b1;
        tch_we = 1'b1;
        vp_we  = 1'b1;
      end
      ST_SEED: begin
        if (src_ok) begin
          sd_we     = 1'b1;
          sd_waddr  = src32[VW-1:0];
          sd_wdata  = '0;
          cd_we     = 1'b1;
          cd_waddr  = src32[VW-1:0];
          cd_wdata  = '0;
          act_we    = 1'b1;
          act_waddr = src32[VW-1:0];
          act_wdata = 1'b1;
          pnd_we    = 1'b1;
          pnd_waddr = src_part_q;
          pnd_wdata = 1'b1;
          ff_we     = 1'b1;
          ff_waddr  = '0;
          ff_wdata  = src_part_q;
        end
      end
      ST_POP: begin
        pnd_we    = 1'b1;
        pnd_waddr = ff_rdata;
      end
      ST_CLR: begin
        imp_we = 1'b1;
        tch_we = 1'b1;
      end
      ST_VA: begin
        sd_raddr = u_q[VW-1:0];
      end
      ST_VB: begin
        row_raddr = u_q + NW'(1);
      end
      ST_EA: begin
        if (e_q >= e1_q) begin
          act_we    = 1'b1;
          act_waddr = u_q[VW-1:0];
        end
      end
      ST_EB: begin
        sd_raddr = tv32[VW-1:0];
        cd_raddr = tv32[VW-1:0];
      end
      ST_EC: begin
        if (alu.lt) begin
          cd_we    = 1'b1;
          cd_waddr = t_q;
          cd_wdata = alu.val;
        end
      end
      ST_ED: begin
        if (alu.lt) begin
          imp_we    = 1'b1;
          imp_waddr = t_q;
          imp_wdata = 1'b1;
        end
        if (!tch_rdata) begin
          tch_we    = 1'b1;
          tch_waddr = pt_q;
          tch_wdata = 1'b1;
        end
      end
      ST_PB: begin
        if (pb_move) begin
          sd_we     = 1'b1;
          sd_wdata  = cd_rdata;
          act_we    = 1'b1;
          act_waddr = idx_q[VW-1:0];
          act_wdata = 1'b1;
        end
        if (pb_push) begin
          sk_we     = 1'b1;
          pnd_we    = 1'b1;
          pnd_waddr = pv_q;
          pnd_wdata = 1'b1;
        end
      end
      ST_SB: begin
        ff_we = 32'(fcnt_q) < MAX_VERTICES;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      run_seen_q  <= 1'b0;
      work_q      <= '0;
      rd_ok_q     <= 1'b0;
      idx_q       <= '0;
      pv_q        <= '0;
      poff_q      <= '0;
      src_part_q  <= '0;
      head_q      <= '0;
      fcnt_q      <= '0;
      scnt_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      u_q         <= '0;
      e_q         <= '0;
      e1_q        <= '0;
      act_q       <= 1'b0;
      psq_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (cmd_e'(command_i))
              CMD_LOAD_ROW, CMD_LOAD_EDGE: begin
                out_valid_q <= 1'b1;
                dist_q      <= '0;
                reached_q   <= 1'b0;
                work_out_q  <= work_q;
                done_q      <= (cmd_e'(command_i) == CMD_LOAD_ROW) ?
                               (slot32 <= MAX_VERTICES) : (slot32 < MAX_EDGES);
              end
              CMD_READ: begin
                rd_ok_q <= slot32 < 32'(n_v);
                state_q <= ST_READ;
              end
              CMD_RUN: begin
                idx_q      <= '0;
                pv_q       <= '0;
                poff_q     <= '0;
                run_seen_q <= 1'b1;
                work_q     <= '0;
                head_q     <= '0;
                fcnt_q     <= '0;
                scnt_q     <= '0;
                psq_q      <= cfg.ps * cfg.ps;
                state_q    <= ST_INIT;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          out_valid_q <= 1'b1;
          work_out_q  <= work_q;
          done_q      <= rd_ok_q;
          // nothing settled before the first run
          if (rd_ok_q && run_seen_q) begin
            dist_q    <= sd_rdata;
            reached_q <= sd_rdata != INF_DIST;
          end else begin
            dist_q    <= INF_DIST;
            reached_q <= 1'b0;
          end
          state_q <= ST_IDLE;
        end
        ST_INIT: begin
          if (32'(idx_q) == src32) begin
            src_part_q <= pv_q;
          end
          poff_q <= last_off ? '0 : poff_q + PS_W'(1);
          pv_q   <= last_off ? pv_q + VW'(1) : pv_q;
          idx_q  <= idx_q + NW'(1);
          if (32'(idx_q) == MAX_VERTICES - 1) begin
            state_q <= ST_SEED;
          end
        end
        ST_SEED: begin
          if (src_ok) begin
            fcnt_q <= NW'(1);
          end
          state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          state_q <= (fcnt_q == '0) ? ST_DONE : ST_POP;
        end
        ST_POP: begin
          lo_q    <= NW'(lo_prod);
          head_q  <= (32'(head_q) == MAX_VERTICES - 1) ? '0 : head_q + VW'(1);
          fcnt_q  <= fcnt_q - NW'(1);
          idx_q   <= '0;
          state_q <= ST_CLR;
        end
        ST_CLR: begin
          hi_q  <= hi32[NW-1:0];
          idx_q <= idx_q + NW'(1);
          if (idx_q + NW'(1) == n_v) begin
            u_q     <= lo_q;
            state_q <= ST_VA;
          end
        end
        ST_VA: begin
          if (u_q >= hi_q) begin
            idx_q   <= '0;
            pv_q    <= '0;
            poff_q  <= '0;
            state_q <= ST_PA;
          end else begin
            state_q <= ST_VB;
          end
        end
        ST_VB: begin
          act_q   <= act_rdata;
          su_q    <= sd_rdata;
          e_q     <= e_clamp;
          state_q <= ST_VC;
        end
        ST_VC: begin
          e1_q <= e_clamp;
          if (act_q) begin
            state_q <= ST_EA;
          end else begin
            u_q     <= u_q + NW'(1);
            state_q <= ST_VA;
          end
        end
        ST_EA: begin
          if (e_q >= e1_q) begin
            u_q     <= u_q + NW'(1);
            state_q <= ST_VA;
          end else begin
            state_q <= ST_EB;
          end
        end
        ST_EB: begin
          t_q <= tv32[VW-1:0];
          w_q <= edge_rdata[WEIGHT_BITS-1:0];
          if (t_ok) begin
            state_q <= ST_EC;
          end else begin
            // skip edges leaving the graph
            e_q     <= e_q + OW'(1);
            state_q <= ST_EA;
          end
        end
        ST_EC: begin
          pt_q    <= vp_rdata;
          newc_q  <= alu.val;
          stt_q   <= sd_rdata;
          state_q <= ST_ED;
        end
        ST_ED: begin
          if (!tch_rdata) begin
            work_q <= work_q + WORK_W'(psq_q);
          end
          e_q     <= e_q + OW'(1);
          state_q <= ST_EA;
        end
        ST_PA: begin
          state_q <= (idx_q == n_v) ? ST_SA : ST_PB;
        end
        ST_PB: begin
          if (pb_push) begin
            scnt_q <= scnt_q + NW'(1);
          end
          idx_q   <= idx_q + NW'(1);
          poff_q  <= last_off ? '0 : poff_q + PS_W'(1);
          pv_q    <= last_off ? pv_q + VW'(1) : pv_q;
          state_q <= ST_PA;
        end
        ST_SA: begin
          state_q <= (scnt_q == '0) ? ST_FETCH : ST_SB;
        end
        ST_SB: begin
          scnt_q <= scnt_m1;
          if (32'(fcnt_q) < MAX_VERTICES) begin
            fcnt_q <= fcnt_q + NW'(1);
          end
          state_q <= ST_SA;
        end
        ST_DONE: begin
          out_valid_q <= 1'b1;
          dist_q      <= '0;
          reached_q   <= 1'b0;
          work_out_q  <= work_q;
          done_q      <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fcnt_q) <= MAX_VERTICES)
    else $error("partition FIFO count above capacity");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(scnt_q) <= MAX_VERTICES)
    else $error("requeue stack count above capacity");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CMD_LOAD_ROW || command_i == CMD_LOAD_EDGE)
    |=> out_valid_o)
    else $error("load transaction produced no result");

  a_run_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> out_valid_o && done_res_o)
    else $error("run finished without a done result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !(out_valid_o && out_stall_i))
    else $error("input accepted while result register is blocked");

endmodule

>>> rtl/core/passsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module passsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/passsp_alu.sv
// Shared saturating add, compare and minimum unit for distance updates.
module passsp_alu
  import passsp_pkg::*;
(
  input  alu_op_e           op_i,
  input  logic [DIST_W-1:0] a_i,
  input  logic [DIST_W-1:0] b_i,
  input  logic [DIST_W-1:0] c_i,
  output alu_res_t          res_o
);

  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sat;
  logic [DIST_W-1:0] x;

  always_comb begin
    sum = {1'b0, a_i} + {1'b0, b_i};
    // clamp just below infinity
    sat = (sum > {1'b0, SAT_DIST}) ? SAT_DIST : sum[DIST_W-1:0];
    x   = (op_i == ALU_RELAX) ? sat : a_i;
    res_o.lt  = x < c_i;
    res_o.val = res_o.lt ? x : c_i;
  end

endmodule

>>> rtl/core/passsp_cfg.sv
// Configuration registers behind the APB-style port.
module passsp_cfg
  import passsp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [VCNT_W-1:0] vcount_q;
  logic [PS_W-1:0]   psize_q;
  logic [SRC_W-1:0]  src_q;
  logic [1:0]        idx;
  logic              wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCNT_W'(1024);
      psize_q  <= PS_W'(16);
      src_q    <= '0;
    end else if (wr) begin
      case (idx)
        REG_VCOUNT: vcount_q <= pwdata[VCNT_W-1:0];
        REG_PSIZE:  psize_q  <= pwdata[PS_W-1:0];
        REG_SOURCE: src_q    <= pwdata[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VCOUNT: prdata = PDATA_W'(vcount_q);
      REG_PSIZE:  prdata = PDATA_W'(psize_q);
      REG_SOURCE: prdata = PDATA_W'(src_q);
      default:    prdata = '0;
    endcase
  end

  // Fold zero and oversize values
  always_comb begin
    if (vcount_q == '0) begin
      cfg_o.n = VCNT_W'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      cfg_o.n = VCNT_W'(MAX_VERTICES);
    end else begin
      cfg_o.n = vcount_q;
    end
    cfg_o.ps  = (psize_q == '0) ? PS_W'(1) : psize_q;
    cfg_o.src = src_q;
  end

endmodule

>>> tb/sv/partitioned_async_sssp_stack_order_top_tb.sv
// Self-checking testbench for the partitioned shortest-path engine top level.
`timescale 1ns / 1ps

module partitioned_async_sssp_stack_order_top_tb
  import passsp_pkg::*;
;

  localparam int          N_MAX      = MAX_VERTICES_DEF;
  localparam int          E_MAX      = MAX_EDGES_DEF;
  localparam int unsigned CYCLE_CAP  = 20_000_000;
  localparam int          RAND_ITEMS = 1900;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reached;
    logic [WORK_W-1:0] work;
    logic              done;
  } result_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [SLOT_W-1:0] slot;
    logic [OFFS_W-1:0] offs;
    logic [TGT_W-1:0]  tgt;
    logic [WGT_W-1:0]  wgt;
    logic              typed;
    result_t           want;
  } item_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [CMD_W-1:0]   command_i      = '0;
  logic [SLOT_W-1:0]  slot_i         = '0;
  logic [OFFS_W-1:0]  offset_value_i = '0;
  logic [TGT_W-1:0]   edge_target_i  = '0;
  logic [WGT_W-1:0]   edge_weight_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [DIST_W-1:0]  distance_o;
  logic               reached_o;
  logic [WORK_W-1:0]  work_count_o;
  logic               done_res_o;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr          = '0;
  logic [PDATA_W-1:0] pwdata         = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  partitioned_async_sssp_stack_order_top u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shadow of the engine
  logic [OFFS_W-1:0] row_mem [0:N_MAX];
  logic [TGT_W-1:0]  tgt_mem [0:E_MAX-1];
  logic [WGT_W-1:0]  wgt_mem [0:E_MAX-1];
  logic [DIST_W-1:0] dist_fixed [0:N_MAX-1];
  logic [DIST_W-1:0] dist_best [0:N_MAX-1];
  bit                vert_live [0:N_MAX-1];
  bit                part_queued [0:N_MAX-1];
  bit                vert_better [0:N_MAX-1];
  bit                part_hit [0:N_MAX-1];
  int unsigned       serve_q [$];
  int unsigned       discover_stk [$];
  logic [WORK_W-1:0] work_acc;
  logic [VCNT_W-1:0] cfg_vcount;
  logic [PS_W-1:0]   cfg_psize;
  logic [SRC_W-1:0]  cfg_source;

  result_t     pending_results [$];
  item_t       stim_q [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned stall_cnt;
  bit          in_calm;
  bit          out_calm;

  function automatic int unsigned live_count();
    if (cfg_vcount == 0) return 1;
    if (cfg_vcount > N_MAX) return N_MAX;
    return cfg_vcount;
  endfunction

  function automatic int unsigned clamp_edge(logic [OFFS_W-1:0] e);
    return (e > E_MAX) ? E_MAX : e;
  endfunction

  function automatic void relax_all();
    int unsigned n, ps, parts, p, lo, hi, e0, e1, t, pv;
    longint unsigned sum;
    n     = live_count();
    ps    = (cfg_psize == 0) ? 1 : cfg_psize;
    parts = (n + ps - 1) / ps;
    for (int i = 0; i < N_MAX; i++) begin
      dist_fixed[i]  = INF_DIST;
      dist_best[i]   = INF_DIST;
      vert_live[i]   = 0;
      part_queued[i] = 0;
      vert_better[i] = 0;
      part_hit[i]    = 0;
    end
    serve_q.delete();
    discover_stk.delete();
    work_acc = '0;
    if (cfg_source < n) begin
      dist_fixed[cfg_source] = '0;
      dist_best[cfg_source]  = '0;
      vert_live[cfg_source]  = 1;
      part_queued[cfg_source / ps] = 1;
      serve_q.push_back(cfg_source / ps);
    end
    while (serve_q.size() > 0) begin
      p = serve_q.pop_front();
      if (p >= parts) continue;
      part_queued[p] = 0;
      for (int i = 0; i < parts; i++) part_hit[i] = 0;
      for (int i = 0; i < n; i++) vert_better[i] = 0;
      lo = p * ps;
      hi = (lo + ps > n) ? n : lo + ps;
      for (int u = lo; u < hi; u++) begin
        if (!vert_live[u]) continue;
        e0 = clamp_edge(row_mem[u]);
        e1 = clamp_edge(row_mem[u+1]);
        for (int e = e0; e < e1; e++) begin
          t = tgt_mem[e];
          if (t >= n) continue;
          if (!part_hit[t / ps]) begin
            part_hit[t / ps] = 1;
            work_acc = work_acc + WORK_W'(ps * ps);
          end
          sum = longint'(dist_fixed[u]) + wgt_mem[e];
          if (sum > SAT_DIST) sum = SAT_DIST;
          if (sum < dist_best[t]) dist_best[t] = DIST_W'(sum);
          if (dist_best[t] < dist_fixed[t]) vert_better[t] = 1;
        end
        vert_live[u] = 0;
      end
      for (int v = 0; v < n; v++) begin
        if (!vert_better[v] || dist_fixed[v] <= dist_best[v]) continue;
        dist_fixed[v] = dist_best[v];
        pv = v / ps;
        if (!part_queued[pv] && discover_stk.size() < N_MAX) begin
          discover_stk.push_back(pv);
          part_queued[pv] = 1;
        end
        vert_live[v] = 1;
      end
      while (discover_stk.size() > 0) begin
        pv = discover_stk.pop_back();
        if (serve_q.size() < N_MAX) serve_q.push_back(pv);
      end
    end
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    r = '0;
    case (it.cmd)
      CMD_LOAD_ROW: begin
        if (it.slot <= N_MAX) begin
          row_mem[it.slot] = it.offs;
          r.done = 1'b1;
        end
      end
      CMD_LOAD_EDGE: begin
        if (it.slot < E_MAX) begin
          tgt_mem[it.slot] = it.tgt;
          wgt_mem[it.slot] = it.wgt;
          r.done = 1'b1;
        end
      end
      CMD_RUN: begin
        relax_all();
        r.done = 1'b1;
      end
      default: begin
        if (it.slot < live_count()) begin
          r.distance = dist_fixed[it.slot];
          r.reached  = (r.distance != INF_DIST);
          r.done     = 1'b1;
        end else begin
          r.distance = INF_DIST;
        end
      end
    endcase
    r.work = work_acc;
    return r;
  endfunction

  function automatic item_t mk(cmd_e c, int slot, int offs, int tgt, int wgt);
    item_t it;
    it      = '0;
    it.cmd  = c;
    it.slot = SLOT_W'(slot);
    it.offs = OFFS_W'(offs);
    it.tgt  = TGT_W'(tgt);
    it.wgt  = WGT_W'(wgt);
    return it;
  endfunction

  function automatic item_t mk_typed(item_t it, logic [DIST_W-1:0] d, logic rch,
                                     logic dn);
    it.typed = 1'b1;
    it.want  = '{distance: d, reached: rch, work: '0, done: dn};
    return it;
  endfunction

  task automatic send(item_t it);
    result_t want;
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= it.cmd;
    slot_i         <= it.slot;
    offset_value_i <= it.offs;
    edge_target_i  <= it.tgt;
    edge_weight_i  <= it.wgt;
    do @(posedge clk_i); while (in_stall_o);
    want = predict_result(it);
    pending_results.push_back(it.typed ? it.want : want);
  endtask

  task automatic reg_write(logic [1:0] idx, int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VCOUNT: cfg_vcount = VCNT_W'(val);
      REG_PSIZE:  cfg_psize  = PS_W'(val);
      default:    cfg_source = SRC_W'(val);
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Build one graph over vertices [0, m) with random rows, then run and read back.
  task automatic build_phase(int unsigned n, int unsigned m, int unsigned src_in);
    int unsigned deg [$];
    int unsigned total, base, acc, k, t, s;
    total = 0;
    for (int u = 0; u < m; u++) begin
      deg.push_back(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4));
      total += deg[u];
    end
    base = ($urandom_range(0, 3) == 0) ? E_MAX - total : $urandom_range(0, E_MAX - total);
    acc = base;
    for (int u = 0; u <= m; u++) begin
      stim_q.push_back(mk(CMD_LOAD_ROW, u, acc, 0, 0));
      if (u < m) acc += deg[u];
    end
    for (int e = 0; e < total; e++) begin
      if (n < N_MAX && $urandom_range(0, 9) == 0) t = $urandom_range(n, N_MAX - 1);
      else t = $urandom_range(0, m - 1);
      k = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
      stim_q.push_back(mk(CMD_LOAD_EDGE, base + e, 0, t, k));
      // Drop in noise that leaves the live graph alone
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: stim_q.push_back(mk(CMD_LOAD_ROW, $urandom_range(m + 1, 8191),
                                 $urandom_range(0, 16383), 0, 0));
          1: begin
            do s = $urandom_range(0, 8191); while (s >= base && s < base + total);
            stim_q.push_back(mk(CMD_LOAD_EDGE, s, 0, $urandom_range(0, 1023),
                                $urandom_range(0, 65535)));
          end
          default: stim_q.push_back(mk(CMD_READ, $urandom_range(0, 8191), 0, 0, 0));
        endcase
      end
    end
    stim_q.push_back(mk(CMD_RUN, $urandom_range(0, 8191), 0, 0, 0));
    for (int r = 0; r < m + 4; r++) begin
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, n + 3);
      stim_q.push_back(mk(CMD_READ, s, $urandom_range(0, 16383), 0, 0));
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check results and pace the result side
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{distance: distance_o, reached: reached_o, work: work_count_o,
              done: done_res_o};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp dist=%0d reached=%0d work=%0d done=%0d,",
                      " got %0d %0d %0d %0d"},
                     want.distance, want.reached, want.work, want.done,
                     got.distance, got.reached, got.work, got.done);
        end
      end
      stall_cnt = out_calm ? 0 : $urandom_range(0, 4);
    end else if (stall_cnt > 0) begin
      stall_cnt--;
    end
    out_stall_i <= (stall_cnt != 0);
  end

  initial begin
    item_t       rows [$];
    int unsigned n, m, vc, ps, src, phase, sent;
    errors     = 0;
    cycles     = 0;
    stall_cnt  = 0;
    in_calm    = 0;
    out_calm   = 0;
    cfg_vcount = VCNT_W'(1024);
    cfg_psize  = PS_W'(16);
    cfg_source = '0;
    work_acc   = '0;
    for (int i = 0; i <= N_MAX; i++) row_mem[i] = '0;
    for (int i = 0; i < E_MAX; i++) begin
      tgt_mem[i] = '0;
      wgt_mem[i] = '0;
    end
    for (int i = 0; i < N_MAX; i++) dist_fixed[i] = INF_DIST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at reset configuration: empty store reads, extremes, clamped rows
    rows.push_back(mk_typed(mk(CMD_READ, 0, 0, 0, 0), INF_DIST, 0, 1));
    rows.push_back(mk_typed(mk(CMD_READ, 8191, 16383, 1023, 65535), INF_DIST, 0, 0));
    rows.push_back(mk_typed(mk(CMD_LOAD_ROW, 8191, 16383, 0, 0), '0, 0, 0));
    rows.push_back(mk_typed(mk(CMD_LOAD_ROW, 0, 0, 0, 0), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_ROW, 1, 3, 0, 0), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_ROW, 2, 4, 0, 0), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_ROW, 3, 4, 0, 0), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_ROW, 1023, 9000, 0, 0), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_ROW, 1024, 16383, 0, 0), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_EDGE, 0, 0, 1, 65535), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_EDGE, 1, 0, 2, 0), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_EDGE, 2, 0, 1023, 7), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_EDGE, 3, 0, 2, 1), '0, 0, 1));
    rows.push_back(mk_typed(mk(CMD_LOAD_EDGE, 8191, 0, 0, 0), '0, 0, 1));
    rows.push_back(mk(CMD_RUN, 0, 0, 0, 0));
    foreach (rows[i]) send(rows[i]);
    rows.delete();
    rows.push_back(mk(CMD_READ, 0, 0, 0, 0));
    rows.push_back(mk(CMD_READ, 1, 0, 0, 0));
    rows.push_back(mk(CMD_READ, 2, 0, 0, 0));
    rows.push_back(mk(CMD_READ, 3, 0, 0, 0));
    rows.push_back(mk(CMD_READ, 1023, 0, 0, 0));
    rows.push_back(mk(CMD_READ, 1024, 0, 0, 0));
    foreach (rows[i]) send(rows[i]);

    phase = 0;
    sent  = 0;
    while (sent < RAND_ITEMS) begin
      case (phase)
        0:       begin vc = 0;    ps = 0;  src = 0;    end
        1:       begin vc = 2047; ps = 64; src = 5;    end
        2:       begin vc = 64;   ps = 1;  src = 63;   end
        3:       begin vc = 20;   ps = 7;  src = 1023; end
        4:       begin vc = 1;    ps = 64; src = 0;    end
        default: begin
          vc = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 2047) : $urandom_range(0, 64);
          ps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
          src = 0;
        end
      endcase
      n = (vc == 0) ? 1 : (vc > N_MAX) ? N_MAX : vc;
      m = $urandom_range(1, (n < 40) ? n : 40);
      if (phase >= 5) begin
        if (n < N_MAX && $urandom_range(0, 7) == 0) src = $urandom_range(n, 1023);
        else src = $urandom_range(0, m - 1);
      end
      if (src < n && m <= src) m = src + 1;
      drain();
      reg_write(REG_VCOUNT, vc);
      reg_write(REG_PSIZE, ps);
      reg_write(REG_SOURCE, src);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      stim_q.delete();
      build_phase(n, m, src);
      foreach (stim_q[i]) send(stim_q[i]);
      sent += stim_q.size();
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
